>>> rtl/core/adagrad_pkg.sv
// shared constants, types and the config register codes for the adagrad update block
// no dependencies
package adagrad_pkg;

  localparam int unsigned StoreDepth = 4096;
  localparam int unsigned IdxW       = 12;
  localparam int unsigned AddrW      = $clog2(StoreDepth);
  localparam int unsigned AccW       = 64;
  localparam int unsigned RootW      = 32;
  localparam int unsigned DenW       = 33;
  localparam int unsigned NumW       = 48;
  localparam int unsigned QDepth     = 4;

  localparam logic [IdxW-1:0] RegLearningRate = IdxW'(0);
  localparam logic [IdxW-1:0] RegEpsilon      = IdxW'(1);

  // one word as it travels from the front to the back
  typedef struct packed {
    logic [IdxW-1:0] index;
    logic            fresh;
    logic [31:0]     weight_in;
    logic            neg;
    logic [31:0]     mag;
  } front_word_t;

endpackage

>>> rtl/core/adagrad_front.sv
// front: queues input words, splitting the gradient into sign and magnitude
// uses adagrad_pkg
module adagrad_front import adagrad_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [IdxW-1:0]    index_i,
  input  logic               fresh_i,
  input  logic signed [31:0] weight_in_i,
  input  logic signed [31:0] gradient_i,
  output logic               q_valid_o,
  input  logic               q_ready_i,
  output front_word_t        q_word_o
);

  front_word_t mem_q [QDepth];
  logic [$clog2(QDepth)-1:0] wp_q, rp_q;
  logic [$clog2(QDepth):0]   cnt_q;
  logic push, pop;
  front_word_t w;

  always_comb begin
    w.index     = index_i;
    w.fresh     = fresh_i;
    w.weight_in = weight_in_i;
    w.neg       = gradient_i[31];
    w.mag       = gradient_i[31] ? 32'(-gradient_i) : gradient_i;
  end

  assign in_ready_o = cnt_q != ($clog2(QDepth)+1)'(QDepth);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = cnt_q != '0;
  assign pop        = q_valid_o && q_ready_i;
  assign q_word_o   = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= wp_q + 1'b1;
      if (pop)  rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + ($clog2(QDepth)+1)'(push) - ($clog2(QDepth)+1)'(pop);
    end
  end

endmodule

>>> rtl/core/adagrad_sqrt.sv
// pipelined integer square root, one result bit per stage
// uses adagrad_pkg
module adagrad_sqrt import adagrad_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [AccW-1:0]  rad_i,
  output logic [RootW-1:0] root_o
);

  logic [AccW-1:0]  rem_q  [RootW+1];
  logic [RootW-1:0] root_q [RootW+1];
  logic [AccW-1:0]  rad_q  [RootW+1];

  always_comb begin
    rem_q[0]  = '0;
    root_q[0] = '0;
    rad_q[0]  = rad_i;
  end

  for (genvar s = 0; s < RootW; s++) begin : g_stage
    logic [AccW+1:0] r2, trial;
    logic [AccW-1:0] rem_n;
    logic [RootW-1:0] root_n;
    always_comb begin
      r2    = {rem_q[s], rad_q[s][AccW-1 -: 2]};
      trial = {root_q[s], 2'b01};
      if (r2 >= trial) begin
        rem_n  = AccW'(r2 - trial);
        root_n = {root_q[s][RootW-2:0], 1'b1};
      end else begin
        rem_n  = AccW'(r2);
        root_n = {root_q[s][RootW-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1]  <= rem_n;
        root_q[s+1] <= root_n;
        rad_q[s+1]  <= {rad_q[s][AccW-3:0], 2'b00};
      end
    end
  end

  assign root_o = root_q[RootW];

endmodule

>>> rtl/core/adagrad_div.sv
// pipelined restoring divider, one quotient bit per stage, quotient kept to 48 bits
// uses adagrad_pkg
module adagrad_div import adagrad_pkg::*; (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic [NumW-1:0] quo_o
);

  logic [DenW:0]   rem_q [NumW+1];
  logic [NumW-1:0] num_q [NumW+1];
  logic [DenW-1:0] den_q [NumW+1];

  always_comb begin
    rem_q[0] = '0;
    num_q[0] = num_i;
    den_q[0] = den_i;
  end

  // num shifts left, quotient bits fill in from the bottom
  for (genvar s = 0; s < NumW; s++) begin : g_stage
    logic [DenW+1:0] sh;
    logic [DenW:0]   rem_n;
    logic            qb;
    always_comb begin
      sh = {rem_q[s], num_q[s][NumW-1]};
      qb = sh >= {2'b00, den_q[s]};
      rem_n = qb ? (DenW+1)'(sh - {2'b00, den_q[s]}) : (DenW+1)'(sh);
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1] <= rem_n;
        num_q[s+1] <= {num_q[s][NumW-2:0], qb};
        den_q[s+1] <= den_q[s];
      end
    end
  end

  assign quo_o = num_q[NumW];

endmodule

>>> rtl/core/adagrad_back.sv
// back: accumulator store with forwarding, then root, divide and saturate pipeline
// uses adagrad_pkg, adagrad_sqrt, adagrad_div
module adagrad_back import adagrad_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [15:0] learning_rate_i,
  input  logic [15:0] epsilon_i,
  input  logic        q_valid_i,
  output logic        q_ready_o,
  input  front_word_t q_word_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] weight_out_o,
  output logic        saturated_o,
  output logic        clear_busy_o
);

  localparam int unsigned Lat = 2 + RootW + 1 + NumW + 1;

  logic [AccW-1:0] store_q [StoreDepth];
  logic [AddrW:0]  clr_q;
  logic            clearing;
  logic            en;
  logic            take;
  logic            inr;

  // stage a: store read and squaring
  logic            a_v_q, a_inr_q, a_fresh_q, a_neg_q;
  logic [AddrW-1:0] a_addr_q;
  logic [AccW-1:0] a_rd_q, a_sq_q;
  logic [31:0]     a_w_q, a_mag_q;
  // stage b: accumulate
  logic            b_v_q, b_neg_q, b_sat_q;
  logic [AccW-1:0] b_acc_q;
  logic [31:0]     b_w_q, b_mag_q;

  logic [AccW-1:0] old, sum;
  logic            carry;

  assign clearing     = clr_q != StoreDepth[AddrW:0];
  assign clear_busy_o = clearing;
  assign en           = !out_valid_o || out_ready_i;
  assign q_ready_o    = en && !clearing;
  assign take         = q_valid_i && q_ready_o;
  assign inr          = {1'b0, q_word_i.index} < (IdxW+1)'(StoreDepth);

  always_ff @(posedge clk_i) begin
    if (clearing) begin
      store_q[clr_q[AddrW-1:0]] <= '0;
    end else if (en && a_v_q && a_inr_q) begin
      store_q[a_addr_q] <= {carry ? {AccW{1'b1}} : sum};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_rd_q    <= store_q[AddrW'(q_word_i.index)];
      a_addr_q  <= AddrW'(q_word_i.index);
      a_inr_q   <= inr;
      a_fresh_q <= q_word_i.fresh;
      a_neg_q   <= q_word_i.neg;
      a_w_q     <= q_word_i.weight_in;
      a_mag_q   <= q_word_i.mag;
      a_sq_q    <= AccW'(q_word_i.mag) * AccW'(q_word_i.mag);
    end
  end

  // forward the slot of the last store write, which the store read missed
  logic [AccW-1:0] fwd_val_q;
  logic [AddrW-1:0] fwd_addr_q;
  logic             fwd_v_q;
  always_comb begin
    if (!a_inr_q || a_fresh_q) old = '0;
    else if (fwd_v_q && fwd_addr_q == a_addr_q) old = fwd_val_q;
    else old = a_rd_q;
    {carry, sum} = {1'b0, old} + {1'b0, a_sq_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q   <= '0;
      a_v_q   <= 1'b0;
      b_v_q   <= 1'b0;
      fwd_v_q <= 1'b0;
    end else begin
      if (clearing) clr_q <= clr_q + 1'b1;
      if (en) begin
        a_v_q   <= take;
        b_v_q   <= a_v_q;
        // fwd holds write of the item leaving stage a; next read is of item entering
        fwd_v_q <= a_v_q && a_inr_q;
      end
    end
  end

  // when the read and the write of stage a hit the same slot in one edge,
  // the registered read is stale; fwd covers that case
  always_ff @(posedge clk_i) begin
    if (en) begin
      fwd_val_q  <= carry ? {AccW{1'b1}} : sum;
      fwd_addr_q <= a_addr_q;
      b_acc_q    <= carry ? {AccW{1'b1}} : sum;
      b_sat_q    <= carry;
      b_neg_q    <= a_neg_q;
      b_w_q      <= a_w_q;
      b_mag_q    <= a_mag_q;
    end
  end

  // side data delayed alongside sqrt
  logic [RootW-1:0] root;
  logic [31:0] s_w_q [RootW+1];
  logic [31:0] s_m_q [RootW+1];
  logic        s_n_q [RootW+1];
  logic        s_s_q [RootW+1];
  always_comb begin
    s_w_q[0] = b_w_q;
    s_m_q[0] = b_mag_q;
    s_n_q[0] = b_neg_q;
    s_s_q[0] = b_sat_q;
  end
  for (genvar i = 0; i < RootW; i++) begin : g_sd
    always_ff @(posedge clk_i) begin
      if (en) begin
        s_w_q[i+1] <= s_w_q[i];
        s_m_q[i+1] <= s_m_q[i];
        s_n_q[i+1] <= s_n_q[i];
        s_s_q[i+1] <= s_s_q[i];
      end
    end
  end

  adagrad_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (b_acc_q),
    .root_o (root)
  );

  // denominator and numerator stage
  logic [DenW-1:0] c_den_q;
  logic [NumW-1:0] c_num_q;
  logic [31:0]     c_w_q;
  logic            c_n_q, c_s_q, c_z_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      c_den_q <= DenW'(root) + DenW'(epsilon_i);
      c_num_q <= NumW'(learning_rate_i) * NumW'(s_m_q[RootW]);
      c_w_q   <= s_w_q[RootW];
      c_n_q   <= s_n_q[RootW];
      c_s_q   <= s_s_q[RootW];
      c_z_q   <= (DenW'(root) + DenW'(epsilon_i)) == '0;
    end
  end

  logic [NumW-1:0] quo;
  logic [31:0] d_w_q [NumW+1];
  logic        d_n_q [NumW+1];
  logic        d_s_q [NumW+1];
  logic        d_z_q [NumW+1];
  always_comb begin
    d_w_q[0] = c_w_q;
    d_n_q[0] = c_n_q;
    d_s_q[0] = c_s_q;
    d_z_q[0] = c_z_q;
  end
  for (genvar i = 0; i < NumW; i++) begin : g_dd
    always_ff @(posedge clk_i) begin
      if (en) begin
        d_w_q[i+1] <= d_w_q[i];
        d_n_q[i+1] <= d_n_q[i];
        d_s_q[i+1] <= d_s_q[i];
        d_z_q[i+1] <= d_z_q[i];
      end
    end
  end

  adagrad_div u_div (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (c_num_q),
    .den_i (c_den_q),
    .quo_o (quo)
  );

  // final apply and saturate
  logic signed [49:0] res;
  logic signed [49:0] stp;
  logic               hi, lo;
  always_comb begin
    stp = d_z_q[NumW] ? '0 : $signed({2'b00, quo});
    res = d_n_q[NumW] ? 50'(signed'(d_w_q[NumW])) + stp
                      : 50'(signed'(d_w_q[NumW])) - stp;
    hi  = res > 50'sd2147483647;
    lo  = res < -50'sd2147483648;
  end

  // valid pipe
  logic [Lat-3:0] v_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[Lat-4:0], b_v_q};
    end
  end

  logic [31:0] wo_q;
  logic        so_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      wo_q <= hi ? 32'h7fffffff : (lo ? 32'h80000000 : res[31:0]);
      so_q <= d_s_q[NumW] || hi || lo;
    end
  end

  assign out_valid_o  = v_q[Lat-3];
  assign weight_out_o = wo_q;
  assign saturated_o  = so_q;

endmodule

>>> rtl/core/adagrad_weight_update.sv
// adagrad weight update: front queue, then store/root/divide pipeline
// one word per cycle sustained while the output is not stalled and the store is not being cleared
// the whole back pipeline advances only when the output register is free
// after reset a clearing pass zeroes the accumulator store; the front queue still
// takes up to four input words during it but none leaves the queue, config writes still are
module adagrad_weight_update import adagrad_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [IdxW-1:0]    cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [IdxW-1:0]    index_i,
  input  logic               fresh_i,
  input  logic signed [31:0] weight_in_i,
  input  logic signed [31:0] gradient_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] weight_out_o,
  output logic               saturated_o
);

  logic [15:0] lr_q, eps_q;
  logic        q_valid, q_ready, busy;
  front_word_t q_word;
  logic [31:0] wo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q  <= 16'd655;
      eps_q <= 16'd1;
    end else if (cfg_we_i) begin
      if (cfg_index_i == RegLearningRate) lr_q <= cfg_data_i;
      if (cfg_index_i == RegEpsilon)      eps_q <= cfg_data_i;
    end
  end

  adagrad_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .index_i     (index_i),
    .fresh_i     (fresh_i),
    .weight_in_i (weight_in_i),
    .gradient_i  (gradient_i),
    .q_valid_o   (q_valid),
    .q_ready_i   (q_ready),
    .q_word_o    (q_word)
  );

  adagrad_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .learning_rate_i (lr_q),
    .epsilon_i       (eps_q),
    .q_valid_i       (q_valid),
    .q_ready_o       (q_ready),
    .q_word_i        (q_word),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .weight_out_o    (wo),
    .saturated_o     (saturated_o),
    .clear_busy_o    (busy)
  );

  assign weight_out_o = signed'(wo);

`ifndef NO_ASSERTIONS
  // nothing leaves the queue while the store is being cleared
  a_no_take_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !q_ready) else $error("queue popped during clear");
  // output word holds while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(weight_out_o))
    else $error("result changed while stalled");
  // clearing ends only once after reset
  a_clear_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |=> !busy) else $error("clear restarted");
`endif

endmodule
